/* src/psrs_pkg.sv */
// ----------------------------------------------------------------------------
// psrs_pkg - shared types and constants of the printable string run scanner
// Record layout, configuration set and register indexes used by all modules.
// ----------------------------------------------------------------------------
package psrs_pkg;

  // record limit per stream, and width of the record counter
  localparam int unsigned MAX_RECORDS = 65536;
  localparam int unsigned REC_CNT_W   = $clog2(MAX_RECORDS + 1);

  // run counter width; equal to the reported length width
  localparam int unsigned LEN_W    = 32;
  localparam int unsigned ADDR_W   = 64;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CODE_W   = 7;
  localparam int unsigned MINLEN_W = 8;

  // records one byte may cause: single-byte, current parity, other parity
  localparam int unsigned NUM_REC = 3;
  localparam int unsigned REC_NARROW  = 0;
  localparam int unsigned REC_WIDE_P  = 1;
  localparam int unsigned REC_WIDE_O  = 2;

  // first code that is no longer printable
  localparam logic [BYTE_W-1:0] CODE_LIMIT = 8'h80;

  // register reset values
  localparam logic [CODE_W-1:0]   MIN_CHAR_RST = 7'd20;
  localparam logic [MINLEN_W-1:0] MIN_LEN_RST  = 8'd4;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_ADDRESS = 3'd0,
    CFG_SEARCH_NARROW = 3'd1,
    CFG_SEARCH_WIDE  = 3'd2,
    CFG_MIN_CHAR     = 3'd3,
    CFG_MIN_LENGTH   = 3'd4
  } cfg_idx_e;

  // run kinds
  localparam logic KIND_NARROW = 1'b0;
  localparam logic KIND_WIDE   = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0]   base_address;
    logic                search_single_byte;
    logic                search_wide;
    logic [CODE_W-1:0]   min_char_code;
    logic [MINLEN_W-1:0] min_length;
  } cfg_t;

  typedef struct packed {
    logic              run_kind;
    logic [ADDR_W-1:0] string_offset;
    logic [LEN_W-1:0]  string_length;
    logic              limit_hit;
    logic              last_of_item;
  } rec_t;

endpackage

/* src/psrs_core.sv */
// ----------------------------------------------------------------------------
// psrs_core - run tracking and record generation
// Updates the run state for one byte and forms up to three records for it.
// ----------------------------------------------------------------------------
module psrs_core
  import psrs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              item_valid_i,
  input  logic [BYTE_W-1:0] data_byte_i,
  input  logic              final_byte_i,
  input  cfg_t              cfg_i,
  output rec_t              rec_o [NUM_REC],
  output logic [NUM_REC-1:0] rec_mask_o
);

  logic [ADDR_W-1:0]    pos_q, pos_d;
  logic [LEN_W-1:0]     nlen_q, nlen_d;
  logic [ADDR_W-1:0]    nstart_q, nstart_d;
  logic [LEN_W-1:0]     wlen_q [2];
  logic [LEN_W-1:0]     wlen_d [2];
  logic [ADDR_W-1:0]    wstart_q [2];
  logic [ADDR_W-1:0]    wstart_d [2];
  logic [BYTE_W-1:0]    prev_q, prev_d;
  logic                 first_q, first_d;
  logic [REC_CNT_W-1:0] cnt_q, cnt_d;
  logic                 halted_q, halted_d;

  logic                 narrow_ok, n_brk, wide_ok, w_brk, par, opar;
  logic [LEN_W-1:0]     nlen_upd, wlen_upd;
  logic [ADDR_W-1:0]    nstart_upd, wstart_upd;
  logic [LEN_W-1:0]     min_len;
  logic [NUM_REC-1:0]   cand_v, emit_v, lim_v, last_v;
  logic [ADDR_W-1:0]    cand_start [NUM_REC];
  logic [LEN_W-1:0]     cand_len [NUM_REC];
  logic [REC_CNT_W-1:0] cnt_t;
  logic                 halt_t, seen;

  // classify the byte and the wide character it closes
  always_comb begin
    min_len    = LEN_W'(cfg_i.min_length);
    par        = pos_q[0];
    opar       = ~pos_q[0];
    narrow_ok  = (data_byte_i >= {1'b0, cfg_i.min_char_code}) && (data_byte_i < CODE_LIMIT);
    wide_ok    = (data_byte_i == '0) && (prev_q >= {1'b0, cfg_i.min_char_code}) &&
                 (prev_q < CODE_LIMIT);
    n_brk      = !narrow_ok || final_byte_i;
    w_brk      = !wide_ok || final_byte_i;

    // extend the single-byte run, saturating
    nlen_upd   = nlen_q;
    nstart_upd = nstart_q;
    if (narrow_ok) begin
      if (nlen_q == '0) nstart_upd = pos_q;
      if (nlen_q != '1) nlen_upd = nlen_q + LEN_W'(1);
    end

    // extend the wide run of this parity, saturating
    wlen_upd   = wlen_q[par];
    wstart_upd = wstart_q[par];
    if (wide_ok) begin
      if (wlen_q[par] == '0) wstart_upd = pos_q - ADDR_W'(1);
      if (wlen_q[par] != '1) wlen_upd = wlen_q[par] + LEN_W'(1);
    end
  end

  // candidate records in delivery order
  always_comb begin
    cand_v[REC_NARROW]     = n_brk && (nlen_upd > min_len) && cfg_i.search_single_byte;
    cand_start[REC_NARROW] = nstart_upd;
    cand_len[REC_NARROW]   = nlen_upd;
    cand_v[REC_WIDE_P]     = !first_q && w_brk && (wlen_upd > min_len) && cfg_i.search_wide;
    cand_start[REC_WIDE_P] = wstart_upd;
    cand_len[REC_WIDE_P]   = wlen_upd;
    cand_v[REC_WIDE_O]     = !first_q && final_byte_i && (wlen_q[opar] > min_len) &&
                             cfg_i.search_wide;
    cand_start[REC_WIDE_O] = wstart_q[opar];
    cand_len[REC_WIDE_O]   = wlen_q[opar];
  end

  // count records against the limit and drop those past it
  always_comb begin
    emit_v = '0;
    lim_v  = '0;
    last_v = '0;
    cnt_t  = cnt_q;
    halt_t = halted_q;
    seen   = 1'b0;
    for (int i = 0; i < NUM_REC; i++) begin
      if (cand_v[i] && !halt_t) begin
        emit_v[i] = 1'b1;
        cnt_t     = cnt_t + REC_CNT_W'(1);
        if (cnt_t == REC_CNT_W'(MAX_RECORDS)) begin
          lim_v[i] = 1'b1;
          halt_t   = 1'b1;
        end
      end
    end
    for (int i = NUM_REC - 1; i >= 0; i--) begin
      last_v[i] = emit_v[i] && !seen;
      seen      = seen | emit_v[i];
    end
  end

  // build the record payloads
  always_comb begin
    for (int i = 0; i < NUM_REC; i++) begin
      rec_o[i].run_kind      = (i == REC_NARROW) ? KIND_NARROW : KIND_WIDE;
      rec_o[i].string_offset = cfg_i.base_address + cand_start[i];
      rec_o[i].string_length = cand_len[i];
      rec_o[i].limit_hit     = lim_v[i];
      rec_o[i].last_of_item  = last_v[i];
    end
    rec_mask_o = (item_valid_i && !halted_q) ? emit_v : '0;
  end

  // next run state
  always_comb begin
    pos_d       = pos_q;
    nlen_d      = nlen_q;
    nstart_d    = nstart_q;
    wlen_d      = wlen_q;
    wstart_d    = wstart_q;
    prev_d      = prev_q;
    first_d     = first_q;
    cnt_d       = cnt_q;
    halted_d    = halted_q;
    if (item_valid_i) begin
      if (!halted_q) begin
        pos_d    = pos_q + ADDR_W'(1);
        prev_d   = data_byte_i;
        first_d  = 1'b0;
        nlen_d   = n_brk ? '0 : nlen_upd;
        nstart_d = nstart_upd;
        if (!first_q) begin
          wlen_d[par]   = w_brk ? '0 : wlen_upd;
          wstart_d[par] = wstart_upd;
        end
        cnt_d    = cnt_t;
        halted_d = halt_t;
      end
      // end of stream: return everything to its reset value
      if (final_byte_i) begin
        pos_d       = '0;
        nlen_d      = '0;
        nstart_d    = '0;
        wlen_d[0]   = '0;
        wlen_d[1]   = '0;
        wstart_d[0] = '0;
        wstart_d[1] = '0;
        prev_d      = '0;
        first_d     = 1'b1;
        cnt_d       = '0;
        halted_d    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      nlen_q      <= '0;
      nstart_q    <= '0;
      wlen_q[0]   <= '0;
      wlen_q[1]   <= '0;
      wstart_q[0] <= '0;
      wstart_q[1] <= '0;
      prev_q      <= '0;
      first_q     <= 1'b1;
      cnt_q       <= '0;
      halted_q    <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      nlen_q   <= nlen_d;
      nstart_q <= nstart_d;
      wlen_q   <= wlen_d;
      wstart_q <= wstart_d;
      prev_q   <= prev_d;
      first_q  <= first_d;
      cnt_q    <= cnt_d;
      halted_q <= halted_d;
    end
  end

endmodule

/* src/psrs_out.sv */
// ----------------------------------------------------------------------------
// psrs_out - record buffer and serialiser
// Holds the records of one byte and hands them out one per request.
// ----------------------------------------------------------------------------
module psrs_out
  import psrs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  rec_t               rec_i [NUM_REC],
  input  logic [NUM_REC-1:0] rec_mask_i,
  output logic               free_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rec_t               out_rec_o
);

  rec_t               rec_q [NUM_REC];
  logic [NUM_REC-1:0] mask_q, mask_d;
  logic [1:0]         head;
  logic               fire;

  // pick the oldest pending record
  always_comb begin
    priority if (mask_q[0]) head = 2'd0;
    else if (mask_q[1])     head = 2'd1;
    else                    head = 2'd2;
  end

  assign out_valid_o = |mask_q;
  assign out_rec_o   = rec_q[head];
  assign fire        = out_valid_o && out_ready_i;
  // free when empty, or once the last pending record leaves in this cycle
  assign free_o      = (mask_q == '0) || ($onehot(mask_q) && out_ready_i);

  // drop delivered records, refill from the core
  always_comb begin
    mask_d = mask_q;
    if (fire) mask_d[head] = 1'b0;
    if (load_i) mask_d = rec_mask_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

  // hold the payloads
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rec_q <= rec_i;
    end
  end

endmodule

/* src/printable_string_run_scanner.sv */
// ----------------------------------------------------------------------------
// printable_string_run_scanner - printable text run finder
// Finds single-byte and UTF-16LE printable runs in a byte stream.
// ----------------------------------------------------------------------------
// Bytes enter on the slave stream, one per request, tlast on the final byte.
// Each byte may close up to three runs; a record is sent on the master stream
// for each closed run longer than min_length whose kind is enabled, with
// tlast on the last record caused by that byte. Records of one byte leave in
// the order single-byte, current-parity wide, other-parity wide.
// A byte is held in an input register until the record buffer is free,
// then processed; its records are registered in the buffer. A byte is
// taken every cycle as long as each byte causes at most one record and the
// receiver keeps tready high; a byte with several records occupies the
// buffer until all are taken. The buffer accepts the next byte's records in
// the cycle its last pending record is taken. When the receiver stalls, the
// buffer holds its records; the register then fills and s_axis_tready drops.
// Reset clears the run state and loads the register defaults; after the
// record limit is reached no records follow until the final byte of the
// stream, which returns the run state to its reset value.
// ----------------------------------------------------------------------------
module printable_string_run_scanner
  import psrs_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // byte stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // [7:0] data_byte
  input  logic                 s_axis_tlast,   // final_byte
  // record stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [95:0]          m_axis_tdata,   // [63:0] string_offset, [95:64] string_length
  output logic [1:0]           m_axis_tuser,   // [0] run_kind, [1] limit_hit
  output logic                 m_axis_tlast,   // last_of_item
  // configuration
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ADDR_W-1:0]    cfg_wdata_i
);

  cfg_t               cfg_q;
  logic               in_valid_q, in_valid_d;
  logic [BYTE_W-1:0]  in_byte_q;
  logic               in_last_q;
  logic               s_fire, process, out_free;
  rec_t               core_rec [NUM_REC];
  logic [NUM_REC-1:0] core_mask;
  rec_t               out_rec;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_address       <= '0;
      cfg_q.search_single_byte <= 1'b0;
      cfg_q.search_wide        <= 1'b0;
      cfg_q.min_char_code      <= MIN_CHAR_RST;
      cfg_q.min_length         <= MIN_LEN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_BASE_ADDRESS:  cfg_q.base_address       <= cfg_wdata_i;
        CFG_SEARCH_NARROW: cfg_q.search_single_byte <= cfg_wdata_i[0];
        CFG_SEARCH_WIDE:   cfg_q.search_wide        <= cfg_wdata_i[0];
        CFG_MIN_CHAR:      cfg_q.min_char_code      <= cfg_wdata_i[CODE_W-1:0];
        CFG_MIN_LENGTH:    cfg_q.min_length         <= cfg_wdata_i[MINLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // input register: advance when the record buffer can take the byte
  assign process       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || process;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (process) in_valid_d = 1'b0;
    if (s_fire)  in_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  psrs_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (process),
    .data_byte_i  (in_byte_q),
    .final_byte_i (in_last_q),
    .cfg_i        (cfg_q),
    .rec_o        (core_rec),
    .rec_mask_o   (core_mask)
  );

  psrs_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (process),
    .rec_i       (core_rec),
    .rec_mask_i  (core_mask),
    .free_o      (out_free),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_rec_o   (out_rec)
  );

  assign m_axis_tdata = {out_rec.string_length, out_rec.string_offset};
  assign m_axis_tuser = {out_rec.limit_hit, out_rec.run_kind};
  assign m_axis_tlast = out_rec.last_of_item;

  // a record that reaches the limit is always the last of its byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
    else $error("limit record not marked last");

  // an empty input register always takes a byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> s_axis_tready)
    else $error("input stalled while empty");

  // a processed byte never overwrites pending records
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    process && m_axis_tvalid && !m_axis_tready |-> 1'b0)
    else $error("record buffer overwritten");

  // a stalled byte keeps the input register full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !out_free |=> in_valid_q)
    else $error("byte lost while stalled");

endmodule
